@@ hw/rtl/ipth_pkg.sv @@
// Package for the IP/transport header parser.
// Holds ethertypes, protocol and port numbers, result codes and the code reader control struct.
// No dependencies.
package ipth_pkg;

    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [15:0] PORT_NTP   = 16'd123;
    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;

    localparam logic [5:0] V6_HDR_BYTES = 6'd40;
    localparam logic [5:0] V4_MIN_BYTES = 6'd20;

    localparam logic [1:0] ST_PARSED = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_BAD_ET = 2'd2;

    localparam logic [1:0] TR_TCP   = 2'd0;
    localparam logic [1:0] TR_UDP   = 2'd1;
    localparam logic [1:0] TR_OTHER = 2'd2;

    localparam logic [2:0] SVC_NONE  = 3'd0;
    localparam logic [2:0] SVC_NTP   = 3'd1;
    localparam logic [2:0] SVC_HTTP  = 3'd2;
    localparam logic [2:0] SVC_QUIC  = 3'd3;
    localparam logic [2:0] SVC_HTTPS = 3'd4;

    typedef struct packed {
        logic clr;   // start of packet, clear before this byte
        logic en;    // byte is part of the code field
        logic done;  // end of packet, clear after this byte
    } t_rdr_ctl;

    // "HTTP/" by character index
    function automatic logic [7:0] http_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/ip_transport_header_parser_unit.sv @@
// Top level of the IP/transport header parser: byte stream in, one header summary per packet out.
// Depends on ipth_pkg and ipth_code_rdr.
//
// channel  dir  tdata                                       tuser        tlast
// s_axis   in   ethertype, data_byte                        first_byte   last_byte
// m_axis   out  status, ip_version, transport, addresses,   -            -
//               ports, service, http_status, captured_length
//
// One byte per cycle while no result stall holds a last byte. Each byte passes through the input register;
// the summary is written to the result register on the cycle the last byte leaves it.
// Synchronous active-low reset empties both registers and clears the byte position and ethertype.
// A stalled result holds only the next last byte and the stream behind it; bytes ahead of it keep flowing.
module ip_transport_header_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // ethertype[15:0], data_byte[23:16]
    input  logic         s_axis_tuser,   // first_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [327:0] m_axis_tdata    // status[1:0], ip_version[2], transport[4:3],
                                         // source_high[68:5], source_low[132:69],
                                         // dest_high[196:133], dest_low[260:197],
                                         // source_port_out[276:261], dest_port_out[292:277],
                                         // service[295:293], http_status[311:296],
                                         // captured_length[327:312]
);
    import ipth_pkg::*;

    // input register
    logic        r_in_valid, r_in_first, r_in_last;
    logic [15:0] r_in_et;
    logic [7:0]  r_in_byte;

    // packet state
    logic [15:0]  r_pos, r_et;
    logic [3:0]   r_ihl, r_doff;
    logic [7:0]   r_proto;
    logic [127:0] r_src, r_dst;
    logic [31:0]  r_ports;
    logic [3:0]   r_match;

    logic [15:0]  cur_pos, cur_et, rel, n_len, base_l;
    logic [3:0]   cur_ihl, n_doff, n_match;
    logic [5:0]   cur_t;
    logic [7:0]   n_proto;
    logic [127:0] n_src, n_dst;
    logic [31:0]  n_ports;
    logic         pkt_start, is_v4, is_v6, in_t, adv;
    t_rdr_ctl     ctl_a, ctl_b;
    logic [15:0]  code_a, code_b;

    // result register
    logic         r_out_valid;
    logic [327:0] r_out;

    logic [1:0]   res_status, res_tr;
    logic         res_ver, tcp_ok, udp_ok, http_room, http_ok;
    logic [63:0]  res_sh, res_sl, res_dh, res_dl;
    logic [15:0]  res_sp, res_dp, res_sel, res_http, t_ext, hl_ext;
    logic [2:0]   res_svc;

    assign adv           = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_comb begin
        cur_pos   = r_in_first ? 16'd0 : r_pos;
        cur_et    = r_in_first ? r_in_et : r_et;
        pkt_start = (cur_pos == 16'd0);
        cur_ihl   = pkt_start ? r_in_byte[3:0] : r_ihl;
        is_v4     = (cur_et == ET_IPV4);
        is_v6     = (cur_et == ET_IPV6);
        cur_t     = is_v6 ? V6_HDR_BYTES : {cur_ihl, 2'b00};
        t_ext     = {10'd0, cur_t};
        in_t      = (cur_pos >= t_ext);
        rel       = cur_pos - t_ext;
        n_len     = (cur_pos == 16'hFFFF) ? cur_pos : cur_pos + 16'd1;

        n_proto = r_proto;
        if ((is_v4 && cur_pos == 16'd9) || (is_v6 && cur_pos == 16'd6)) begin
            n_proto = r_in_byte;
        end

        n_src = r_src;
        if ((is_v4 && cur_pos >= 16'd12 && cur_pos <= 16'd15) ||
            (is_v6 && cur_pos >= 16'd8 && cur_pos <= 16'd23)) begin
            n_src = {r_src[119:0], r_in_byte};
        end
        n_dst = r_dst;
        if ((is_v4 && cur_pos >= 16'd16 && cur_pos <= 16'd19) ||
            (is_v6 && cur_pos >= 16'd24 && cur_pos <= 16'd39)) begin
            n_dst = {r_dst[119:0], r_in_byte};
        end

        n_ports = r_ports;
        if (in_t && rel < 16'd4) begin
            n_ports = {r_ports[23:0], r_in_byte};
        end

        n_doff = r_doff;
        if (in_t && rel == 16'd12) begin
            n_doff = r_in_byte[7:4];
        end

        // prefix match at payload offset 0, 4, 8 (offset known late) and at the registered offset
        n_match = pkt_start ? 4'b1111 : r_match;
        for (int c = 0; c < 3; c++) begin
            if (in_t && rel >= 16'(c * 4) && rel < 16'(c * 4 + 5) &&
                r_in_byte != http_char(rel[2:0] - 3'(c * 4))) begin
                n_match[c] = 1'b0;
            end
        end
        base_l = {10'd0, r_doff, 2'b00};
        if (in_t && rel > 16'd12 && rel >= base_l && rel < base_l + 16'd5 &&
            r_in_byte != http_char(rel[2:0] - base_l[2:0])) begin
            n_match[3] = 1'b0;
        end

        ctl_b.clr  = r_in_first;
        ctl_b.done = r_in_last;
        ctl_b.en   = in_t && rel >= 16'd9;
        ctl_a.clr  = r_in_first;
        ctl_a.done = r_in_last;
        ctl_a.en   = in_t && rel > 16'd12 && r_doff != 4'd0 && rel >= base_l + 16'd9;
    end

    ipth_code_rdr u_rdr_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (ctl_a),
        .i_byte  (r_in_byte),
        .o_code  (code_a)
    );

    // starts at transport offset 9, used when the data offset is zero
    ipth_code_rdr u_rdr_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (ctl_b),
        .i_byte  (r_in_byte),
        .o_code  (code_b)
    );

    always_comb begin
        hl_ext    = {10'd0, n_doff, 2'b00};
        tcp_ok    = (n_proto == PROTO_TCP) && (n_len >= t_ext + 16'd20);
        udp_ok    = (n_proto == PROTO_UDP) && (n_len >= t_ext + 16'd8);
        http_room = (n_len >= t_ext + hl_ext + 16'd12);
        case (n_doff)
            4'd0:    http_ok = n_match[0];
            4'd1:    http_ok = n_match[1];
            4'd2:    http_ok = n_match[2];
            4'd3:    http_ok = 1'b0;
            default: http_ok = n_match[3];
        endcase
        http_ok = http_ok && http_room && tcp_ok;

        res_ver    = is_v6;
        res_status = ST_PARSED;
        if (!is_v4 && !is_v6) begin
            res_status = ST_BAD_ET;
            res_ver    = 1'b0;
        end else if (n_len < (is_v6 ? {10'd0, V6_HDR_BYTES} : {10'd0, V4_MIN_BYTES})) begin
            res_status = ST_SHORT;
        end

        res_sh = is_v6 ? n_src[127:64] : 64'd0;
        res_sl = is_v6 ? n_src[63:0] : {32'd0, n_src[31:0]};
        res_dh = is_v6 ? n_dst[127:64] : 64'd0;
        res_dl = is_v6 ? n_dst[63:0] : {32'd0, n_dst[31:0]};

        res_tr = TR_OTHER;
        res_sp = 16'd0;
        res_dp = 16'd0;
        if (tcp_ok) begin
            res_tr = TR_TCP;
            res_sp = n_ports[31:16];
            res_dp = n_ports[15:0];
        end else if (udp_ok) begin
            res_tr = TR_UDP;
            res_sp = n_ports[31:16];
            res_dp = n_ports[15:0];
        end

        res_sel = (res_sp == PORT_NTP || res_sp == PORT_HTTP || res_sp == PORT_HTTPS) ?
                  res_sp : res_dp;
        if (res_sel == PORT_NTP) begin
            res_svc = SVC_NTP;
        end else if (res_sel == PORT_HTTP) begin
            res_svc = SVC_HTTP;
        end else if (res_sel == PORT_HTTPS) begin
            res_svc = (res_tr == TR_UDP) ? SVC_QUIC : SVC_HTTPS;
        end else begin
            res_svc = SVC_NONE;
        end

        res_http = (res_svc == SVC_HTTP && http_ok) ?
                   ((n_doff == 4'd0) ? code_b : code_a) : 16'd0;

        if (res_status != ST_PARSED) begin
            res_tr   = TR_OTHER;
            res_sh   = 64'd0;
            res_sl   = 64'd0;
            res_dh   = 64'd0;
            res_dl   = 64'd0;
            res_sp   = 16'd0;
            res_dp   = 16'd0;
            res_svc  = SVC_NONE;
            res_http = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= 16'd0;
            r_et        <= 16'd0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_pos <= r_in_last ? 16'd0 : n_len;
                r_et  <= cur_et;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_et    <= s_axis_tdata[15:0];
            r_in_byte  <= s_axis_tdata[23:16];
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
        if (adv) begin
            r_ihl   <= cur_ihl;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_ports <= n_ports;
            r_doff  <= n_doff;
            r_match <= n_match;
        end
        if (adv && r_in_last) begin
            r_out <= {n_len, res_http, res_svc, res_dp, res_sp, res_dl, res_dh,
                      res_sl, res_sh, res_tr, res_ver, res_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    a_pos_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_pos == 16'd0)
        else $error("byte position not cleared at packet end");

    a_not_parsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out[1:0] != ST_PARSED |->
        r_out[4:3] == TR_OTHER && r_out[311:261] == 51'd0)
        else $error("unparsed packet with transport fields");

    a_http_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out[311:296] != 16'd0 |->
        r_out[295:293] == SVC_HTTP && r_out[4:3] == TR_TCP)
        else $error("status code without HTTP over TCP");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !(adv && r_in_last))
        else $error("pending result overwritten");

endmodule

@@ hw/rtl/ipth_code_rdr.sv @@
// Status code reader: blanks, optional sign, decimal digits, saturating at 65535.
// One byte per transaction; exposes the code value including the current byte.
// Depends on ipth_pkg.
module ipth_code_rdr (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  ipth_pkg::t_rdr_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic [15:0]       o_code
);
    import ipth_pkg::*;

    localparam logic [1:0] PH_BLANK = 2'd0;
    localparam logic [1:0] PH_DIGIT = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    logic [1:0]  r_phase, n_phase, base_phase;
    logic        r_neg, n_neg, base_neg;
    logic [15:0] r_acc, n_acc, base_acc, acc_dig;
    logic [19:0] mac;
    logic        is_digit, is_blank;

    always_comb begin
        base_phase = i_ctl.clr ? PH_BLANK : r_phase;
        base_neg   = i_ctl.clr ? 1'b0 : r_neg;
        base_acc   = i_ctl.clr ? 16'd0 : r_acc;

        is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        is_blank = (i_byte == 8'h20) || ((i_byte >= 8'h09) && (i_byte <= 8'h0D));

        mac     = {base_acc, 3'b000} + {2'b00, base_acc, 1'b0} + {16'd0, i_byte[3:0]};
        acc_dig = (mac > 20'd65535) ? 16'hFFFF : mac[15:0];

        n_phase = base_phase;
        n_neg   = base_neg;
        n_acc   = base_acc;
        if (i_ctl.en) begin
            unique case (base_phase)
                PH_BLANK: begin
                    if (is_blank) begin
                        n_phase = PH_BLANK;
                    end else if (i_byte == 8'h2B) begin
                        n_phase = PH_DIGIT;
                    end else if (i_byte == 8'h2D) begin
                        n_neg   = 1'b1;
                        n_phase = PH_DIGIT;
                    end else if (is_digit) begin
                        n_acc   = acc_dig;
                        n_phase = PH_DIGIT;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGIT: begin
                    if (is_digit) begin
                        n_acc = acc_dig;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: n_phase = base_phase;
            endcase
        end
    end

    assign o_code = n_neg ? 16'd0 : n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BLANK;
            r_neg   <= 1'b0;
            r_acc   <= 16'd0;
        end else if (i_adv) begin
            if (i_ctl.done) begin
                r_phase <= PH_BLANK;
                r_neg   <= 1'b0;
                r_acc   <= 16'd0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
            end
        end
    end

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_ctl.done |=> r_acc == 16'd0 && !r_neg && r_phase == PH_BLANK)
        else $error("code reader not cleared after packet end");

    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_neg && !i_ctl.clr |-> o_code == 16'd0)
        else $error("negative code not forced to zero");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("code reader phase corrupt");

endmodule

@@ tb/ip_transport_header_parser_checker.sv @@
// Scoreboard for ip_transport_header_parser_unit: watches both stream channels,
// rebuilds the header summary of each packet from the accepted bytes and compares it.
// Depends on ipth_pkg.
module ip_transport_header_parser_checker
    import ipth_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // ethertype[15:0], data_byte[23:16]
    input  logic         s_axis_tuser,   // first_byte
    input  logic         s_axis_tlast,   // last_byte
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [327:0] m_axis_tdata,   // status, ip_version, transport, addresses,
                                         // ports, service, http_status, captured_length
    output int           o_fail_count,
    output int           o_pending,
    output int           o_summaries
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = 144;
    localparam logic [39:0] HTTP_TAG = "HTTP/";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {SKIP_BLANKS, READ_DIGITS, CODE_DONE} code_phase_e;

    // MSB first, so the struct overlays m_axis_tdata directly
    typedef struct packed {
        logic [15:0] captured_length;
        logic [15:0] http_status;
        logic [2:0]  service;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [63:0] dest_low;
        logic [63:0] dest_high;
        logic [63:0] source_low;
        logic [63:0] source_high;
        logic [1:0]  transport;
        logic        ip_version;
        logic [1:0]  status;
    } summary_t;

    logic [7:0]  hdr_bytes [STORE_BYTES];
    logic [15:0] byte_count;
    logic [15:0] pkt_ethertype;
    code_phase_e code_phase;
    logic        code_minus;
    logic [15:0] code_value;
    summary_t    pending_summaries[$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void clear_code();
        code_phase = SKIP_BLANKS;
        code_minus = 1'b0;
        code_value = '0;
    endfunction

    function automatic void feed_code(logic [7:0] c);
        logic        is_digit;
        logic [19:0] scaled;
        logic [15:0] next_value;
        is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        scaled     = 20'(code_value) * 20'd10 + 20'(c - CH_ZERO);
        next_value = (scaled > 20'd65535) ? 16'hFFFF : scaled[15:0];
        case (code_phase)
            SKIP_BLANKS: begin
                if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                    if (c == CH_PLUS) begin
                        code_phase = READ_DIGITS;
                    end else if (c == CH_MINUS) begin
                        code_minus = 1'b1;
                        code_phase = READ_DIGITS;
                    end else if (is_digit) begin
                        code_value = next_value;
                        code_phase = READ_DIGITS;
                    end else begin
                        code_phase = CODE_DONE;
                    end
                end
            end
            READ_DIGITS: begin
                if (is_digit) code_value = next_value;
                else code_phase = CODE_DONE;
            end
            default: ;
        endcase
    endfunction

    // runs the code reader over stored bytes from the code start up to index last
    function automatic void replay_code(int last);
        int hdr_len;
        int code_start;
        if (pkt_ethertype == ET_IPV4) hdr_len = 4 * int'(hdr_bytes[0][3:0]);
        else if (pkt_ethertype == ET_IPV6) hdr_len = int'(V6_HDR_BYTES);
        else return;
        if (hdr_len + 12 > last || hdr_len + 12 >= STORE_BYTES) return;
        code_start = hdr_len + 4 * int'(hdr_bytes[hdr_len + 12][7:4]) + 9;
        for (int i = code_start; i <= last && i < STORE_BYTES; i++) feed_code(hdr_bytes[i]);
    endfunction

    function automatic logic [63:0] be_field(int at, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v = {v[55:0], hdr_bytes[(at + i) % STORE_BYTES]};
        return v;
    endfunction

    function automatic bit parse_byte(input logic [15:0] ethertype, input logic [7:0] data,
                                      input logic first, input logic last,
                                      output summary_t s);
        int          idx;
        int          len;
        int          hdr_len;
        int          min_len;
        int          rem;
        int          tcp_len;
        int          p;
        logic [7:0]  proto;
        logic [15:0] sel;
        logic        http_ok;
        s       = '0;
        http_ok = 1'b0;
        if (first) begin
            byte_count    = '0;
            pkt_ethertype = ethertype;
            clear_code();
        end
        idx = int'(byte_count);
        if (idx < STORE_BYTES) hdr_bytes[idx] = data;
        if (idx == STORE_BYTES) begin
            replay_code(STORE_BYTES - 1);
            feed_code(data);
        end else if (idx > STORE_BYTES) begin
            feed_code(data);
        end
        byte_count = (idx < 65535) ? 16'(idx + 1) : 16'hFFFF;
        if (!last) return 1'b0;

        if (idx < STORE_BYTES) replay_code(idx);
        len                 = int'(byte_count);
        byte_count          = '0;
        s.transport         = TR_OTHER;
        s.captured_length   = 16'(len);
        if (pkt_ethertype == ET_IPV4) begin
            min_len = int'(V4_MIN_BYTES);
            hdr_len = 4 * int'(hdr_bytes[0][3:0]);
            proto   = hdr_bytes[9];
        end else if (pkt_ethertype == ET_IPV6) begin
            s.ip_version = 1'b1;
            min_len      = int'(V6_HDR_BYTES);
            hdr_len      = int'(V6_HDR_BYTES);
            proto        = hdr_bytes[6];
        end else begin
            s.status = ST_BAD_ET;
            clear_code();
            return 1'b1;
        end
        if (len < min_len) begin
            s.status = ST_SHORT;
            clear_code();
            return 1'b1;
        end

        s.status = ST_PARSED;
        if (s.ip_version) begin
            s.source_high = be_field(8, 8);
            s.source_low  = be_field(16, 8);
            s.dest_high   = be_field(24, 8);
            s.dest_low    = be_field(32, 8);
        end else begin
            s.source_low = be_field(12, 4);
            s.dest_low   = be_field(16, 4);
        end

        rem = len - hdr_len;
        if (proto == PROTO_TCP && rem >= 20) begin
            tcp_len       = 4 * int'(hdr_bytes[hdr_len + 12][7:4]);
            s.transport   = TR_TCP;
            s.source_port = 16'(be_field(hdr_len, 2));
            s.dest_port   = 16'(be_field(hdr_len + 2, 2));
            if (rem > tcp_len && rem - tcp_len >= 12) begin
                p       = hdr_len + tcp_len;
                http_ok = {hdr_bytes[p], hdr_bytes[p + 1], hdr_bytes[p + 2],
                           hdr_bytes[p + 3], hdr_bytes[p + 4]} == HTTP_TAG;
            end
        end else if (proto == PROTO_UDP && rem >= 8) begin
            s.transport   = TR_UDP;
            s.source_port = 16'(be_field(hdr_len, 2));
            s.dest_port   = 16'(be_field(hdr_len + 2, 2));
        end

        sel = (s.source_port == PORT_NTP || s.source_port == PORT_HTTP ||
               s.source_port == PORT_HTTPS) ? s.source_port : s.dest_port;
        if (sel == PORT_NTP) s.service = SVC_NTP;
        else if (sel == PORT_HTTP) s.service = SVC_HTTP;
        else if (sel == PORT_HTTPS) s.service = (s.transport == TR_UDP) ? SVC_QUIC : SVC_HTTPS;

        if (s.service == SVC_HTTP && http_ok && !code_minus) s.http_status = code_value;
        clear_code();
        return 1'b1;
    endfunction

    function automatic void check_field(int n, string name, logic [63:0] want,
                                        logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("MISMATCH summary %0d %s: expected %0h, got %0h", n, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        summary_t want;
        summary_t got;
        if (!i_rst_n) begin
            foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
            byte_count    = '0;
            pkt_ethertype = '0;
            clear_code();
            pending_summaries.delete();
            o_summaries <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_byte(s_axis_tdata[15:0], s_axis_tdata[23:16], s_axis_tuser,
                               s_axis_tlast, want))
                    pending_summaries.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_summaries.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("MISMATCH unexpected summary: got %0h", got);
                end else begin
                    want = pending_summaries.pop_front();
                    check_field(o_summaries, "status", want.status, got.status);
                    check_field(o_summaries, "ip_version", want.ip_version, got.ip_version);
                    check_field(o_summaries, "transport", want.transport, got.transport);
                    check_field(o_summaries, "source_high", want.source_high, got.source_high);
                    check_field(o_summaries, "source_low", want.source_low, got.source_low);
                    check_field(o_summaries, "dest_high", want.dest_high, got.dest_high);
                    check_field(o_summaries, "dest_low", want.dest_low, got.dest_low);
                    check_field(o_summaries, "source_port", want.source_port, got.source_port);
                    check_field(o_summaries, "dest_port", want.dest_port, got.dest_port);
                    check_field(o_summaries, "service", want.service, got.service);
                    check_field(o_summaries, "http_status", want.http_status, got.http_status);
                    check_field(o_summaries, "captured_length", want.captured_length,
                                got.captured_length);
                end
                o_summaries <= o_summaries + 1;
            end
        end
        o_pending <= pending_summaries.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the header parser testbench: clock, reset, byte-stream stimulus and result-side
// back-pressure for ip_transport_header_parser_unit; verdict from the checker's count.
// Depends on ipth_pkg, ip_transport_header_parser_unit and ip_transport_header_parser_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ipth_pkg::*;

    localparam int IDLE_PCT       = 18;
    localparam int HOLD_CYCLES    = 400;
    localparam int LONG_PKT_BYTES = 65540;
    localparam int RAND_BYTES     = 1800;
    localparam int RAND_PACKETS   = 60;
    localparam logic [39:0] HTTP_TAG = "HTTP/";
    localparam logic [39:0] BAD_TAG  = "HTTX/";

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata  = '0;   // ethertype[15:0], data_byte[23:16]
    logic         s_axis_tuser  = 1'b0; // first_byte
    logic         s_axis_tlast  = 1'b0; // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [327:0] m_axis_tdata;         // status .. captured_length, see block header

    int           fail_count;
    int           pending;
    int           summaries;
    bit           quiet        = 1'b0;
    int           bytes_sent   = 0;
    int           packets_sent = 0;
    logic [7:0]   pkt[$];
    string        code_txt;

    always #5 i_clk = ~i_clk;

    ip_transport_header_parser_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ip_transport_header_parser_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_summaries   (summaries)
    );

    // builds pkt: IP header, transport header at the IHL offset (40 for IPv6), tag and code text in the
    // payload; cap_len 0 keeps the natural length
    function automatic void make_pkt(input logic [15:0] ethertype, input logic [7:0] proto,
                                     input logic [3:0] ihl, input logic [15:0] sport,
                                     input logic [15:0] dport, input logic [3:0] toff,
                                     input logic [39:0] tag, input int cap_len);
        int t;
        int p;
        int n;
        t = (ethertype == ET_IPV6) ? 40 : 4 * int'(ihl);
        p = t + 4 * int'(toff);
        n = (cap_len > 320) ? cap_len : 320;
        pkt.delete();
        repeat (n) pkt.push_back(8'($urandom));
        pkt[t]      = sport[15:8];
        pkt[t + 1]  = sport[7:0];
        pkt[t + 2]  = dport[15:8];
        pkt[t + 3]  = dport[7:0];
        pkt[t + 12] = {toff, pkt[t + 12][3:0]};
        for (int i = 0; i < 5; i++) pkt[p + i] = tag[39 - 8 * i -: 8];
        for (int i = 0; i < code_txt.len(); i++) pkt[p + 9 + i] = code_txt[i];
        if (ethertype == ET_IPV6) begin
            pkt[6] = proto;
        end else begin
            pkt[0] = {4'h4, ihl};
            pkt[9] = proto;
        end
        if (cap_len == 0) cap_len = p + 12 + code_txt.len();
        while (pkt.size() > cap_len) void'(pkt.pop_back());
    endfunction

    task automatic send_pkt(input logic [15:0] ethertype, input bit mark_first,
                            input bit mark_last, input int noise_pct);
        for (int i = 0; i < pkt.size(); i++) begin
            while (!quiet && $urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {pkt[i], (i == 0) ? ethertype : 16'($urandom)};
            s_axis_tuser  <= (i == 0) ? mark_first : ($urandom_range(99) < noise_pct);
            s_axis_tlast  <= (i == pkt.size() - 1) ? mark_last :
                             ($urandom_range(99) < noise_pct);
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            bytes_sent++;
        end
        packets_sent++;
    endtask

    task automatic run_pkt(input logic [15:0] ethertype, input logic [7:0] proto,
                           input logic [3:0] ihl, input logic [15:0] sport,
                           input logic [15:0] dport, input logic [3:0] toff,
                           input logic [39:0] tag, input string code, input int cap_len);
        code_txt = code;
        make_pkt(ethertype, proto, ihl, sport, dport, toff, tag, cap_len);
        send_pkt(ethertype, 1'b1, 1'b1, 0);
    endtask

    function automatic logic [15:0] pick_port();
        case ($urandom_range(4))
            0:       return PORT_HTTP;
            1:       return PORT_NTP;
            2:       return PORT_HTTPS;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic string rand_code();
        string chars = " \t+-x0123456789012345678901234567890123456789";
        string txt   = "";
        int    k;
        repeat ($urandom_range(1, 8)) begin
            k   = $urandom_range(chars.len() - 1);
            txt = {txt, chars.substr(k, k)};
        end
        return txt;
    endfunction

    // result side: random stalls, one long hold-off once ten summaries are out
    initial begin
        int seen      = 0;
        int hold_left = 0;
        bit held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (m_axis_tvalid && m_axis_tready) seen++;
                if (hold_left > 0) begin
                    hold_left--;
                    m_axis_tready <= 1'b0;
                end else if (!held && seen >= 10) begin
                    held      = 1'b1;
                    hold_left = HOLD_CYCLES;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [15:0] et;
        logic [7:0]  proto;
        int          n;
        int          rand_start;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // HTTP code reading
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'd50123, 5, HTTP_TAG, " 200 OK", 0);
        run_pkt(ET_IPV4, PROTO_TCP, 5, 16'd40000, PORT_HTTP, 5, HTTP_TAG, "+404", 0);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'hFFFF, 5, HTTP_TAG, "-1", 0);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'h0000, 5, HTTP_TAG, "  99999999", 0);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'd1234, 5, HTTP_TAG, "abc", 0);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'd1234, 5, HTTP_TAG, "\t\n\v\f 301", 0);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'd1234, 5, BAD_TAG, "200", 0);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'd1234, 5, HTTP_TAG, "200", 51);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'd1234, 5, HTTP_TAG, "  7", 52);
        // services and transports
        run_pkt(ET_IPV4, PROTO_UDP, 5, PORT_NTP, 16'd999, 5, HTTP_TAG, "1", 0);
        run_pkt(ET_IPV4, PROTO_UDP, 5, 16'd5555, PORT_HTTPS, 5, HTTP_TAG, "1", 0);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTPS, PORT_HTTP, 5, HTTP_TAG, "1", 0);
        run_pkt(ET_IPV6, PROTO_TCP, 5, 16'd8080, PORT_HTTP, 5, HTTP_TAG, "503", 0);
        run_pkt(ET_IPV6, PROTO_UDP, 5, 16'd8080, PORT_HTTP, 5, HTTP_TAG, "200", 0);
        run_pkt(ET_IPV4, 8'd1, 5, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, "200", 0);
        // short captures and unsupported ethertypes
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, "200", 19);
        run_pkt(ET_IPV6, PROTO_TCP, 5, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, "200", 39);
        run_pkt(16'hFFFF, PROTO_TCP, 5, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, "200", 30);
        run_pkt(16'h0000, PROTO_UDP, 5, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, "200", 30);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, "200", 39);
        // IHL and data offset oddities
        run_pkt(ET_IPV4, PROTO_TCP, 0, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, "200", 0);
        run_pkt(ET_IPV4, PROTO_UDP, 2, PORT_NTP, PORT_NTP, 5, HTTP_TAG, "200", 0);
        run_pkt(ET_IPV4, PROTO_TCP, 15, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, "200", 70);
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, PORT_HTTP, 0, HTTP_TAG, "200", 60);
        // code that runs past the stored header bytes
        run_pkt(ET_IPV4, PROTO_TCP, 15, PORT_HTTP, 16'd1, 15, HTTP_TAG,
                "                    42", 0);
        // all-zero and all-one packets
        pkt.delete();
        repeat (64) pkt.push_back(8'h00);
        send_pkt(ET_IPV4, 1'b1, 1'b1, 0);
        pkt.delete();
        repeat (64) pkt.push_back(8'hFF);
        send_pkt(ET_IPV6, 1'b1, 1'b1, 0);
        // single byte, missing last mark, missing first mark
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, "200", 1);
        code_txt = "200";
        make_pkt(ET_IPV6, PROTO_TCP, 5, PORT_HTTP, PORT_HTTP, 5, HTTP_TAG, 30);
        send_pkt(ET_IPV6, 1'b1, 1'b0, 0);
        run_pkt(ET_IPV4, PROTO_UDP, 5, PORT_HTTPS, 16'd7, 5, HTTP_TAG, "1", 0);
        code_txt = "418";
        make_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'd7, 5, HTTP_TAG, 0);
        send_pkt(16'hFFFF, 1'b0, 1'b1, 0);
        // byte count saturation
        run_pkt(ET_IPV4, PROTO_TCP, 5, PORT_HTTP, 16'd9, 5, HTTP_TAG, "999999",
                LONG_PKT_BYTES);

        rand_start = bytes_sent;
        n = 0;
        while (bytes_sent - rand_start < RAND_BYTES || n < RAND_PACKETS) begin
            quiet = (n >= 20 && n < 35);
            case ($urandom_range(9))
                0, 1, 2, 3: et = ET_IPV4;
                4, 5, 6, 7: et = ET_IPV6;
                default:    et = 16'($urandom);
            endcase
            if ($urandom_range(99) < 15) begin
                // broken framing: random bytes and stray marks
                pkt.delete();
                repeat ($urandom_range(1, 48)) pkt.push_back(8'($urandom));
                send_pkt(et, 1'($urandom), 1'($urandom), 10);
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: proto = PROTO_TCP;
                    5, 6, 7:       proto = PROTO_UDP;
                    default:       proto = 8'($urandom);
                endcase
                run_pkt(et, proto,
                        ($urandom_range(99) < 80) ? 4'd5 : 4'($urandom),
                        pick_port(), pick_port(),
                        ($urandom_range(99) < 80) ? 4'd5 : 4'($urandom),
                        ($urandom_range(99) < 60) ? HTTP_TAG : 40'($urandom),
                        rand_code(),
                        ($urandom_range(99) < 75) ? 0 : int'($urandom_range(1, 100)));
            end
            n++;
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d packets (%0d bytes), %0d header summaries compared.",
                 packets_sent, bytes_sent, summaries);
        $display("Mix: IPv4/IPv6 TCP/UDP, HTTP codes, short and bad frames, %0d-byte capture.",
                 LONG_PKT_BYTES);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
